/* sv/ohlc_bar_aggregator_unit_defines.svh */
// Assertion macros for the OHLC bar aggregator RTL (used by ohlc_back).
// Needs clk and rst in scope where used.
`ifndef OHLC_BAR_AGGREGATOR_UNIT_DEFINES_SVH
`define OHLC_BAR_AGGREGATOR_UNIT_DEFINES_SVH
// same-cycle implication
`define OHLC_AST_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ohlc assertion failed");
// next-cycle implication
`define OHLC_AST_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ohlc assertion failed");
`endif

/* sv/ohlc_pkg.sv */
// Types and constants for the OHLC bar aggregator.
// No dependencies.
package ohlc_pkg;
  localparam int TIME_W = 63;
  localparam int SYM_W  = 16;
  localparam int PRICE_W = 32;
  localparam int SIZE_W = 32;
  localparam int VOL_W  = 48;
  localparam int LEN_W  = 47;
  localparam int CNT_W  = 6;
  localparam logic [LEN_W-1:0] LEN_RESET = 47'd300000000000;

  typedef struct packed {
    logic [TIME_W-1:0]  trade_time;
    logic [SYM_W-1:0]   trade_symbol;
    logic [PRICE_W-1:0] trade_price;
    logic [SIZE_W-1:0]  trade_size;
    logic               end_of_stream;
  } trade_t;

  typedef struct packed {
    logic [TIME_W-1:0]  bar_start;
    logic [SYM_W-1:0]   bar_symbol;
    logic [PRICE_W-1:0] bar_open;
    logic [PRICE_W-1:0] bar_high;
    logic [PRICE_W-1:0] bar_low;
    logic [PRICE_W-1:0] bar_close;
    logic [VOL_W-1:0]   bar_volume;
    logic               last_of_run;
  } bar_t;

  // trade with its interval start resolved
  typedef struct packed {
    logic [TIME_W-1:0] start;
    trade_t            trade;
  } item_t;
endpackage

/* sv/ohlc_front.sv */
// Front end: takes trades, works out interval start by a bit-serial remainder.
// Uses ohlc_pkg.
module ohlc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  ohlc_pkg::trade_t           trade,
  input  logic [ohlc_pkg::LEN_W-1:0] interval_length,
  output logic                       q_push,
  input  logic                       q_full,
  output ohlc_pkg::item_t            q_item
);
  import ohlc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state;
  trade_t            tr;
  logic [LEN_W-1:0]  len;
  logic [LEN_W:0]    rem;
  logic [CNT_W-1:0]  cnt;
  logic [LEN_W:0]    shifted;

  assign full    = (state != ST_IDLE);
  assign shifted = {rem[LEN_W-1:0], tr.trade_time[cnt]};
  assign q_push  = (state == ST_DONE) && !q_full;
  assign q_item.start = tr.trade_time - {{(TIME_W-LEN_W-1){1'b0}}, rem};
  assign q_item.trade = tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (push) begin
            tr    <= trade;
            len   <= (interval_length == '0) ? LEN_W'(1) : interval_length;
            rem   <= '0;
            cnt   <= CNT_W'(TIME_W - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (shifted >= {1'b0, len}) rem <= shifted - {1'b0, len};
          else rem <= shifted;
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= ST_DONE;
        end
        ST_DONE: begin
          if (!q_full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

/* sv/ohlc_queue.sv */
// Two-entry queue between front and back end.
// Uses ohlc_pkg.
module ohlc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  ohlc_pkg::item_t din,
  input  logic            pop,
  output logic            empty,
  output ohlc_pkg::item_t dout
);
  import ohlc_pkg::*;

  item_t      mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign dout    = mem[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

/* sv/ohlc_back.sv */
// Back end: holds the open bar, updates it and emits finished bars.
// Uses ohlc_pkg and the assertion macros header.
`include "ohlc_bar_aggregator_unit_defines.svh"
module ohlc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  ohlc_pkg::item_t q_item,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output ohlc_pkg::bar_t  bar
);
  import ohlc_pkg::*;

  bar_t   cur, upd, old_bar, new_bar, pbar, obar;
  logic   active, pend, ovalid;
  logic   slot_free, same, eos, emit_old;
  logic [VOL_W:0] vsum;

  assign slot_free = !ovalid || pop;
  assign q_pop     = !q_empty && !pend && slot_free;
  assign eos       = q_item.trade.end_of_stream;
  assign same      = active && (q_item.start == cur.bar_start);
  assign emit_old  = active && !same;
  assign vsum      = {1'b0, cur.bar_volume} + (VOL_W+1)'(q_item.trade.trade_size);
  assign empty     = !ovalid;
  assign bar       = obar;

  always_comb begin
    upd = cur;
    if (same) begin
      if (q_item.trade.trade_price > cur.bar_high) upd.bar_high = q_item.trade.trade_price;
      if (q_item.trade.trade_price < cur.bar_low) upd.bar_low = q_item.trade.trade_price;
      upd.bar_close  = q_item.trade.trade_price;
      upd.bar_volume = vsum[VOL_W] ? '1 : vsum[VOL_W-1:0];
    end else begin
      upd.bar_start  = q_item.start;
      upd.bar_symbol = q_item.trade.trade_symbol;
      upd.bar_open   = q_item.trade.trade_price;
      upd.bar_high   = q_item.trade.trade_price;
      upd.bar_low    = q_item.trade.trade_price;
      upd.bar_close  = q_item.trade.trade_price;
      upd.bar_volume = VOL_W'(q_item.trade.trade_size);
    end
    upd.last_of_run = 1'b1;
    old_bar = cur;
    old_bar.last_of_run = !eos;
    new_bar = upd;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= upd;
    if (pend && slot_free) begin
      obar <= pbar;
    end else if (q_pop) begin
      obar <= emit_old ? old_bar : new_bar;
      if (emit_old && eos) pbar <= new_bar;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (q_pop) active <= !eos;
      priority if (pend && slot_free) begin
        ovalid <= 1'b1;
        pend   <= 1'b0;
      end else if (q_pop) begin
        ovalid <= emit_old || eos;
        pend   <= emit_old && eos;
      end else begin
        if (pop) ovalid <= 1'b0;
      end
    end
  end

  `OHLC_AST_NOW(a_pend_has_out, pend, ovalid)
  `OHLC_AST_NOW(a_no_take_while_pend, q_pop, !pend)
  `OHLC_AST_NXT(a_out_held, ovalid && !pop, ovalid)
endmodule

/* sv/ohlc_bar_aggregator_unit.sv */
// Top level of the OHLC bar aggregator: front end, queue, back end.
// Uses ohlc_pkg, ohlc_front, ohlc_queue, ohlc_back.
//
// channel   dir  handshake        payload
// trade     in   push / full      ohlc_pkg::trade_t
// bar       out  pop / empty      ohlc_pkg::bar_t
// interval  cfg  interval_we      interval_length (47 bits)
//
// In the front end a trade is loaded, goes through 63 remainder steps (one bit
// of the timestamp per cycle) and is handed over to the queue when it has room.
// The back end updates the open bar from each trade and puts out up to two bars.
// Reset (rst, synchronous) empties both sides, closes the bar and sets the
// interval to LEN_RESET. Either side may stall; the queue decouples them.
module ohlc_bar_aggregator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  ohlc_pkg::trade_t           trade,
  output logic                       empty,
  input  logic                       pop,
  output ohlc_pkg::bar_t             bar,
  input  logic                       interval_we,
  input  logic [ohlc_pkg::LEN_W-1:0] interval_length
);
  import ohlc_pkg::*;

  logic [LEN_W-1:0] len_reg;
  logic  fq_push, fq_full, bq_pop, bq_empty;
  item_t fq_item, bq_item;

  always_ff @(posedge clk) begin
    if (rst) len_reg <= LEN_RESET;
    else if (interval_we) len_reg <= interval_length;
  end

  ohlc_front u_front (
    .clk, .rst, .push, .full, .trade,
    .interval_length(len_reg),
    .q_push(fq_push), .q_full(fq_full), .q_item(fq_item)
  );

  ohlc_queue u_queue (
    .clk, .rst,
    .push(fq_push), .full(fq_full), .din(fq_item),
    .pop(bq_pop), .empty(bq_empty), .dout(bq_item)
  );

  ohlc_back u_back (
    .clk, .rst,
    .q_empty(bq_empty), .q_item(bq_item), .q_pop(bq_pop),
    .empty, .pop, .bar
  );
endmodule
